### design/best_fit_heap_allocator_defines.svh
// Assertion macros shared by the checker.
`ifndef BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define BEST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Implication that is checked outside reset.
`define BFHA_ASSERT_IMP(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("check failed");

// Next-cycle implication that is checked outside reset.
`define BFHA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("check failed");

`endif

### design/bfha_pkg.sv
`default_nettype none
package bfha_pkg;
	localparam int HeapBytes = 65536;
	localparam int HeaderBytes = 16;
	localparam int MinSplitBytes = 16;
	localparam int MaxBlocks = 64;
	localparam int IdxW = $clog2(MaxBlocks);
	localparam int CntW = $clog2(MaxBlocks + 1);

	localparam logic [1:0] StDone = 2'd0;
	localparam logic [1:0] StAllocFail = 2'd1;
	localparam logic [1:0] StBadFree = 2'd2;

	localparam logic OpAlloc = 1'b0;
	localparam logic OpFree = 1'b1;

	typedef struct packed {
		logic [31:0] free_total;
		logic [31:0] alloc_total;
		logic [16:0] unused_bytes;
		logic [16:0] used_bytes;
		logic [1:0]  status;
		logic [15:0] result_offset;
	} result_t;
endpackage
`default_nettype wire

### design/best_fit_heap_allocator.sv
// Best-fit heap allocator over a 64 KiB heap, tracked in a 64-entry block table.
// Input beat (s_axis): tdata = {payload_offset, request_size, opcode}, opcode in bit 0.
//   opcode 0 allocates request_size bytes (rounded up to 8), opcode 1 frees a payload
//   offset. One result beat (m_axis) follows every input beat, carrying the result
//   offset, status and the running byte and call statistics.
// The block takes one request at a time: s_axis_tready is low from acceptance until
// the result has been taken on m_axis. A request walks the table one entry per cycle
// through a registered table read port on a single compare/add datapath:
//   allocate: a search pass and a decide step, plus a shift pass when the chosen
//     block is split; a zero size goes straight to the result as an allocation failure.
//   free: a search pass, a decide step, then a merge pass that compacts the table in
//     one sweep.
// Reset (arst_n low) zeroes the call counts and sets the byte counts to one free block;
// S_INIT then writes that block, covering the heap, into entry 0 with s_axis_tready low.
// The result is held in the output register while m_axis_tready is low.
`default_nettype none
module best_fit_heap_allocator
	import bfha_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // opcode[0], request_size[17:1], payload_offset[33:18]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [119:0]     m_axis_tdata   // result_offset, status, used_bytes, unused_bytes,
	                                        // alloc_total, free_total
);
	typedef enum logic [2:0] {
		S_INIT, S_IDLE, S_SCAN, S_DECIDE, S_SHIFT, S_MERGE, S_OUT
	} state_t;

	logic [15:0] start_mem [MaxBlocks];
	logic [16:0] pay_mem [MaxBlocks];
	logic        free_mem [MaxBlocks];

	state_t       state_q;
	logic         op_q;
	logic [17:0]  need_q;
	logic [15:0]  off_q;
	logic [CntW-1:0] count_q;
	logic [CntW-1:0] i_q;
	logic [CntW-1:0] j_q;
	logic         found_q;
	logic [IdxW-1:0] best_q;
	logic [16:0]  best_pay_q;
	logic [15:0]  best_start_q;
	logic [16:0]  used_q, unused_q;
	logic [31:0]  alloc_q, free_q;
	logic [15:0]  res_off_q;
	logic [1:0]   status_q;
	logic         acc_free_q;
	logic [15:0]  acc_start_q;
	logic [16:0]  acc_pay_q;
	logic         acc_valid_q;
	logic         rd_ok_q;
	logic [IdxW-1:0] rd_idx_q;
	logic [15:0]  rd_start_q;
	logic [16:0]  rd_pay_q;
	logic         rd_free_q;

	logic [16:0] req_size;
	logic [17:0] need_rnd;
	logic [IdxW-1:0] i_idx;
	logic [17:0] split_lim;
	logic [16:0] sz;
	logic [CntW-1:0] best_nx;
	logic        do_split;
	logic        merge_hit;
	logic        issue;
	logic [IdxW-1:0] rd_addr;
	logic        we_start, we_pay, we_free;
	logic [IdxW-1:0] waddr;
	logic [15:0] wstart;
	logic [16:0] wpay;
	logic        wfree;

	assign req_size  = s_axis_tdata[17:1];
	assign need_rnd  = ({1'b0, req_size} + 18'd7) & ~18'd7;
	assign i_idx     = i_q[IdxW-1:0];
	assign split_lim = need_q + 18'(HeaderBytes + MinSplitBytes);
	assign sz        = best_pay_q + 17'(HeaderBytes);
	assign best_nx   = CntW'(best_q) + CntW'(1);
	assign do_split  = ({1'b0, best_pay_q} >= split_lim) && (count_q < CntW'(MaxBlocks));
	assign merge_hit = acc_valid_q && acc_free_q && rd_free_q;

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = (state_q == S_OUT);
	assign m_axis_tdata  = {4'd0, free_q, alloc_q, unused_q, used_q, status_q, res_off_q};

	// Table read address and the single write port.
	always_comb begin
		issue    = 1'b0;
		rd_addr  = i_idx;
		we_start = 1'b0;
		we_pay   = 1'b0;
		we_free  = 1'b0;
		waddr    = '0;
		wstart   = '0;
		wpay     = '0;
		wfree    = 1'b0;
		case (state_q)
			S_INIT: begin
				we_start = 1'b1;
				we_pay   = 1'b1;
				we_free  = 1'b1;
				wpay     = 17'(HeapBytes - HeaderBytes);
				wfree    = 1'b1;
			end
			S_SCAN: begin
				issue = (i_q != count_q) && !(op_q == OpFree && found_q);
			end
			S_DECIDE: begin
				if (found_q) begin
					waddr   = best_q;
					we_free = 1'b1;
					wfree   = (op_q == OpFree);
					if (op_q == OpAlloc && do_split) begin
						we_pay = 1'b1;
						wpay   = need_q[16:0];
					end
				end
			end
			S_SHIFT: begin
				// Read one below, write it back one above on the next cycle.
				issue   = (i_q != best_nx);
				rd_addr = i_idx - IdxW'(1);
				if (rd_ok_q) begin
					waddr    = rd_idx_q + IdxW'(1);
					we_start = 1'b1;
					we_pay   = 1'b1;
					we_free  = 1'b1;
					wstart   = rd_start_q;
					wpay     = rd_pay_q;
					wfree    = rd_free_q;
				end else if (!issue) begin
					waddr    = best_nx[IdxW-1:0];
					we_start = 1'b1;
					we_pay   = 1'b1;
					we_free  = 1'b1;
					wstart   = best_start_q + 16'(HeaderBytes) + need_q[15:0];
					wpay     = best_pay_q - need_q[16:0] - 17'(HeaderBytes);
					wfree    = 1'b1;
				end
			end
			S_MERGE: begin
				issue  = (i_q != count_q);
				waddr  = j_q[IdxW-1:0];
				wstart = acc_start_q;
				wpay   = acc_pay_q;
				wfree  = acc_free_q;
				if ((rd_ok_q && !merge_hit && acc_valid_q) ||
				    (!rd_ok_q && !issue && acc_valid_q)) begin
					we_start = 1'b1;
					we_pay   = 1'b1;
					we_free  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we_start) start_mem[waddr] <= wstart;
		if (we_pay)   pay_mem[waddr]   <= wpay;
		if (we_free)  free_mem[waddr]  <= wfree;
		rd_start_q <= start_mem[rd_addr];
		rd_pay_q   <= pay_mem[rd_addr];
		rd_free_q  <= free_mem[rd_addr];
		rd_idx_q   <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			count_q   <= CntW'(1);
			used_q    <= 17'(HeaderBytes);
			unused_q  <= 17'(HeapBytes - HeaderBytes);
			alloc_q   <= '0;
			free_q    <= '0;
			rd_ok_q   <= 1'b0;
		end else begin
			rd_ok_q <= issue;
			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_axis_tvalid) begin
						op_q      <= s_axis_tdata[0];
						need_q    <= need_rnd;
						off_q     <= s_axis_tdata[33:18];
						i_q       <= '0;
						found_q   <= 1'b0;
						res_off_q <= '0;
						if (s_axis_tdata[0] == OpAlloc && req_size == '0) begin
							status_q <= StAllocFail;
							state_q  <= S_OUT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// One entry a cycle: best fit for allocate, exact match for free.
					if (issue) i_q <= i_q + CntW'(1);
					if (rd_ok_q) begin
						if (op_q == OpAlloc) begin
							if (rd_free_q && {1'b0, rd_pay_q} >= need_q &&
							    (!found_q || rd_pay_q < best_pay_q)) begin
								found_q      <= 1'b1;
								best_q       <= rd_idx_q;
								best_pay_q   <= rd_pay_q;
								best_start_q <= rd_start_q;
							end
						end else if (!found_q && !rd_free_q &&
						             rd_start_q + 16'(HeaderBytes) == off_q) begin
							found_q    <= 1'b1;
							best_q     <= rd_idx_q;
							best_pay_q <= rd_pay_q;
						end
					end else if (!issue) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (!found_q) begin
						status_q <= (op_q == OpAlloc) ? StAllocFail : StBadFree;
						state_q  <= S_OUT;
					end else if (op_q == OpAlloc) begin
						status_q  <= StDone;
						alloc_q   <= alloc_q + 32'd1;
						res_off_q <= best_start_q + 16'(HeaderBytes);
						if (do_split) begin
							used_q   <= used_q + need_q[16:0] + 17'(HeaderBytes);
							unused_q <= unused_q - need_q[16:0] - 17'(HeaderBytes);
							i_q      <= count_q;
							state_q  <= S_SHIFT;
						end else begin
							used_q   <= used_q + sz;
							unused_q <= unused_q - sz;
							state_q  <= S_OUT;
						end
					end else begin
						status_q <= StDone;
						free_q   <= free_q + 32'd1;
						used_q   <= used_q - sz;
						unused_q <= unused_q + sz;
						i_q         <= '0;
						j_q         <= '0;
						acc_valid_q <= 1'b0;
						state_q     <= S_MERGE;
					end
				end
				S_SHIFT: begin
					// Move entries up from the top; drop the remainder in behind best.
					if (issue) i_q <= i_q - CntW'(1);
					if (!rd_ok_q && !issue) begin
						count_q <= count_q + CntW'(1);
						state_q <= S_OUT;
					end
				end
				S_MERGE: begin
					// Read at i, accumulate one block, write compacted entries at j.
					if (issue) i_q <= i_q + CntW'(1);
					if (rd_ok_q) begin
						if (merge_hit) begin
							acc_pay_q <= acc_pay_q + 17'(HeaderBytes) + rd_pay_q;
						end else begin
							if (acc_valid_q) j_q <= j_q + CntW'(1);
							acc_valid_q <= 1'b1;
							acc_start_q <= rd_start_q;
							acc_pay_q   <= rd_pay_q;
							acc_free_q  <= rd_free_q;
						end
					end else if (!issue) begin
						count_q <= j_q + CntW'(acc_valid_q);
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (m_axis_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### design/bfha_checker.sv
`default_nettype none
`include "best_fit_heap_allocator_defines.svh"
module bfha_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic [39:0]  s_axis_tdata,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [119:0] m_axis_tdata
);
	`BFHA_ASSERT_IMP(a_one_side, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	`BFHA_ASSERT_NEXT(a_busy_after_in, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`BFHA_ASSERT_NEXT(a_hold_out, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
	`BFHA_ASSERT_IMP(a_status_code, clk, arst_n, m_axis_tvalid, m_axis_tdata[17:16] != 2'd3)
	`BFHA_ASSERT_IMP(a_fail_zero, clk, arst_n, m_axis_tvalid && m_axis_tdata[17:16] != 2'd0,
		m_axis_tdata[15:0] == 16'd0)
endmodule

bind best_fit_heap_allocator bfha_checker u_bfha_checker (.*);
`default_nettype wire

### sim/best_fit_heap_allocator_tb.sv
`default_nettype none
module best_fit_heap_allocator_tb;
	import bfha_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [119:0] m_axis_tdata;

	best_fit_heap_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// block table copy
	logic [15:0] tbl_start [MaxBlocks];
	logic [16:0] tbl_payload [MaxBlocks];
	logic tbl_free [MaxBlocks];
	int unsigned tbl_count;
	logic [16:0] used_sum;
	logic [16:0] unused_sum;
	logic [31:0] alloc_cnt;
	logic [31:0] free_cnt;

	logic [39:0] request_q[$];
	result_t expected_q[$];
	logic [15:0] live_offsets[$];
	int failures = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	function automatic void heap_reset();
		tbl_start[0] = 16'd0;
		tbl_payload[0] = 17'(HeapBytes - HeaderBytes);
		tbl_free[0] = 1'b1;
		tbl_count = 1;
		used_sum = 17'(HeaderBytes);
		unused_sum = 17'(HeapBytes - HeaderBytes);
		alloc_cnt = '0;
		free_cnt = '0;
	endfunction

	function automatic void drop_entry(int unsigned idx);
		for (int unsigned k = idx; k + 1 < tbl_count; k++) begin
			tbl_start[k] = tbl_start[k + 1];
			tbl_payload[k] = tbl_payload[k + 1];
			tbl_free[k] = tbl_free[k + 1];
		end
		tbl_count--;
	endfunction

	function automatic result_t heap_apply(logic [39:0] beat);
		result_t r;
		logic op;
		logic [16:0] size;
		logic [15:0] off;
		int unsigned need, best, rest, blk;
		bit found;
		op = beat[0];
		size = beat[17:1];
		off = beat[33:18];
		r = '0;
		if (op == OpAlloc) begin
			r.status = StAllocFail;
			found = 0;
			best = 0;
			need = (int'(size) + 7) & ~7;
			if (size != 0) begin
				for (int unsigned i = 0; i < tbl_count; i++)
					if (tbl_free[i] && tbl_payload[i] >= need &&
						(!found || tbl_payload[i] < tbl_payload[best])) begin
						best = i;
						found = 1;
					end
			end
			if (found) begin
				if (tbl_payload[best] >= need + HeaderBytes + MinSplitBytes &&
					tbl_count < MaxBlocks) begin
					rest = tbl_payload[best] - need - HeaderBytes;
					for (int unsigned k = tbl_count; k > best + 1; k--) begin
						tbl_start[k] = tbl_start[k - 1];
						tbl_payload[k] = tbl_payload[k - 1];
						tbl_free[k] = tbl_free[k - 1];
					end
					tbl_start[best + 1] = 16'(tbl_start[best] + HeaderBytes + need);
					tbl_payload[best + 1] = 17'(rest);
					tbl_free[best + 1] = 1'b1;
					tbl_payload[best] = 17'(need);
					tbl_count++;
				end
				tbl_free[best] = 1'b0;
				used_sum = 17'(used_sum + tbl_payload[best] + HeaderBytes);
				unused_sum = 17'(unused_sum - tbl_payload[best] - HeaderBytes);
				alloc_cnt++;
				r.status = StDone;
				r.result_offset = 16'(tbl_start[best] + HeaderBytes);
			end
		end else begin
			r.status = StBadFree;
			blk = tbl_count;
			for (int unsigned i = 0; i < tbl_count; i++)
				if (blk == tbl_count && !tbl_free[i] &&
					16'(tbl_start[i] + HeaderBytes) == off)
					blk = i;
			if (blk < tbl_count) begin
				tbl_free[blk] = 1'b1;
				used_sum = 17'(used_sum - tbl_payload[blk] - HeaderBytes);
				unused_sum = 17'(unused_sum + tbl_payload[blk] + HeaderBytes);
				free_cnt++;
				r.status = StDone;
				for (int unsigned i = 0; i + 1 < tbl_count;) begin
					if (tbl_free[i] && tbl_free[i + 1]) begin
						tbl_payload[i] = 17'(tbl_payload[i] + HeaderBytes + tbl_payload[i + 1]);
						drop_entry(i + 1);
					end else begin
						i++;
					end
				end
			end
		end
		r.used_bytes = used_sum;
		r.unused_bytes = unused_sum;
		r.alloc_total = alloc_cnt;
		r.free_total = free_cnt;
		return r;
	endfunction

	function automatic logic [39:0] pack_req(logic op, logic [16:0] size, logic [15:0] off);
		return {6'd0, off, size, op};
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= request_q.pop_front();
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// predict on accepted input beats
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			expected_q.push_back(heap_apply(s_axis_tdata));
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		result_t got, exp_r;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[115:0]);
				if (expected_q.size() == 0) begin
					$error("result beat with nothing expected: %h", m_axis_tdata);
					failures++;
				end else begin
					exp_r = expected_q.pop_front();
					if (got.result_offset !== exp_r.result_offset) begin
						$error("result_offset exp %0d got %0d", exp_r.result_offset,
							got.result_offset);
						failures++;
					end
					if (got.status !== exp_r.status) begin
						$error("status exp %0d got %0d", exp_r.status, got.status);
						failures++;
					end
					if (got.used_bytes !== exp_r.used_bytes) begin
						$error("used_bytes exp %0d got %0d", exp_r.used_bytes, got.used_bytes);
						failures++;
					end
					if (got.unused_bytes !== exp_r.unused_bytes) begin
						$error("unused_bytes exp %0d got %0d", exp_r.unused_bytes,
							got.unused_bytes);
						failures++;
					end
					if (got.alloc_total !== exp_r.alloc_total) begin
						$error("alloc_total exp %0d got %0d", exp_r.alloc_total,
							got.alloc_total);
						failures++;
					end
					if (got.free_total !== exp_r.free_total) begin
						$error("free_total exp %0d got %0d", exp_r.free_total, got.free_total);
						failures++;
					end
				end
			end
		end
	end

	task automatic wait_drained();
		while (request_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
			@(posedge clk);
	endtask

	// random size: mostly small, a few large
	function automatic logic [16:0] pick_size();
		int unsigned sel;
		sel = $urandom_range(99);
		if (sel < 70)
			return 17'($urandom_range(1, 256));
		else if (sel < 90)
			return 17'($urandom_range(1, 4096));
		else if (sel < 96)
			return 17'($urandom_range(0, 131071));
		return 17'(0);
	endfunction

	// model of what the stimulus believes is live, used to aim frees
	task automatic random_phase(int n);
		logic [15:0] off;
		int idx, sel;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 50 || live_offsets.size() == 0) begin
				request_q.push_back(pack_req(OpAlloc, pick_size(), 16'($urandom)));
			end else if (sel < 90) begin
				idx = $urandom_range(live_offsets.size() - 1);
				off = live_offsets[idx];
				live_offsets.delete(idx);
				request_q.push_back(pack_req(OpFree, 17'($urandom), off));
			end else begin
				request_q.push_back(pack_req(OpFree, 17'($urandom), 16'($urandom)));
			end
			if (request_q.size() > 0 && request_q[$][0] == OpAlloc) begin
				// learn the offset once predicted
				wait_drained();
				if (tbl_count > 0)
					for (int unsigned k = 0; k < tbl_count; k++)
						if (!tbl_free[k] && !(16'(tbl_start[k] + HeaderBytes) inside {live_offsets}))
							live_offsets.push_back(16'(tbl_start[k] + HeaderBytes));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		heap_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: zero size, tiny, exact fit without split, invalid frees, extremes
		request_q.push_back(pack_req(OpAlloc, 17'd0, 16'hFFFF));
		request_q.push_back(pack_req(OpAlloc, 17'd1, 16'd0));
		request_q.push_back(pack_req(OpAlloc, 17'd65536, 16'd0));
		request_q.push_back(pack_req(OpAlloc, 17'h1FFFF, 16'd0));
		request_q.push_back(pack_req(OpFree, 17'h1FFFF, 16'd16));
		request_q.push_back(pack_req(OpFree, 17'd0, 16'd16));
		request_q.push_back(pack_req(OpFree, 17'd0, 16'd20));
		request_q.push_back(pack_req(OpFree, 17'd0, 16'hFFFF));
		request_q.push_back(pack_req(OpAlloc, 17'd7, 16'd0));
		request_q.push_back(pack_req(OpAlloc, 17'd8, 16'd0));
		request_q.push_back(pack_req(OpAlloc, 17'd9, 16'd0));
		request_q.push_back(pack_req(OpFree, 17'd0, 16'd32));
		request_q.push_back(pack_req(OpFree, 17'd0, 16'd48));
		request_q.push_back(pack_req(OpAlloc, 17'd16, 16'd0));
		request_q.push_back(pack_req(OpFree, 17'd0, 16'd16));
		request_q.push_back(pack_req(OpFree, 17'd0, 16'd56));
		request_q.push_back(pack_req(OpFree, 17'd0, 16'd32));
		// not whole: full-heap request fails, small one reuses first block, then free
		request_q.push_back(pack_req(OpAlloc, 17'(HeapBytes - HeaderBytes), 16'd0));
		request_q.push_back(pack_req(OpAlloc, 17'd8, 16'd0));
		request_q.push_back(pack_req(OpFree, 17'd0, 16'd16));
		wait_drained();
		// full table: 64 allocations; one takes the remainder whole, later ones fail
		for (int i = 0; i < 64; i++)
			request_q.push_back(pack_req(OpAlloc, 17'd8, 16'd0));
		wait_drained();
		for (int i = 0; i < 64; i++)
			request_q.push_back(pack_req(OpFree, 17'd0, 16'(16 + 24 * i)));
		wait_drained();
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 72; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 72; end
				default: begin send_idle_pct = 31; recv_stall_pct = 31; end
			endcase
			random_phase(150);
			wait_drained();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_phase(60);
		wait_drained();
		repeat (200) @(posedge clk);
		if (failures == 0)
			$display("[best_fit_heap_allocator] OK");
		else
			$display("[best_fit_heap_allocator] ERROR");
		$finish;
	end

	initial begin
		#20ms;
		$display("[best_fit_heap_allocator] ERROR");
		$finish;
	end
endmodule
`default_nettype wire
